@@ hdl/ipv4dd_pkg.sv @@
// shared types, character codes and digit helpers for the dotted-decimal formatter
package ipv4dd_pkg;

	// ascii codes, trimmed to the six-bit character port
	localparam logic [5:0] ASCII_ZERO = 6'd48;
	localparam logic [5:0] ASCII_DOT  = 6'd46;

	// an octet split into hundreds, tens and ones
	typedef struct packed {
		logic [1:0] hun;
		logic [3:0] ten;
		logic [3:0] one;
	} bcd_t;

	// four octets, index 0 is the first octet (address bits 31:24)
	typedef bcd_t [3:0] bcd_quad_t;

	// significant digits left aligned, last_idx is the index of the final digit
	typedef struct packed {
		logic [3:0] d0;
		logic [3:0] d1;
		logic [3:0] d2;
		logic [1:0] last_idx;
	} digits_t;

	typedef digits_t [3:0] digits_quad_t;

	// octet to decimal digits: hundreds by compare, tens by reciprocal multiply
	function automatic bcd_t octet_to_bcd(input logic [7:0] v);
		logic [7:0]  rem;
		logic [15:0] prod;
		logic [3:0]  tens;
		logic [7:0]  tens10;
		bcd_t        r;
		if (v >= 8'd200) begin
			r.hun = 2'd2;
			rem   = v - 8'd200;
		end else if (v >= 8'd100) begin
			r.hun = 2'd1;
			rem   = v - 8'd100;
		end else begin
			r.hun = 2'd0;
			rem   = v;
		end
		// rem stays below one hundred, where rem * 205 >> 11 equals rem / 10
		prod   = {8'd0, rem} * 16'd205;
		tens   = prod[14:11];
		tens10 = 8'({tens, 3'b000}) + 8'({tens, 1'b0});
		r.ten  = tens;
		r.one  = 4'(rem - tens10);
		return r;
	endfunction

	// drop leading zeros, keeping at least the ones digit
	function automatic digits_t bcd_to_digits(input bcd_t b);
		digits_t r;
		if (b.hun != 2'd0) begin
			r.d0       = {2'b00, b.hun};
			r.d1       = b.ten;
			r.d2       = b.one;
			r.last_idx = 2'd2;
		end else if (b.ten != 4'd0) begin
			r.d0       = b.ten;
			r.d1       = b.one;
			r.d2       = 4'd0;
			r.last_idx = 2'd1;
		end else begin
			r.d0       = b.one;
			r.d1       = 4'd0;
			r.d2       = 4'd0;
			r.last_idx = 2'd0;
		end
		return r;
	endfunction

endpackage

@@ hdl/ipv4dd_split.sv @@
// pipeline stage that splits each octet into decimal digits
module ipv4dd_split (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [31:0]           in_address,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ipv4dd_pkg::bcd_quad_t out_bcd
);
	import ipv4dd_pkg::*;

	logic      valid_s2;
	bcd_quad_t bcd_s2;

	// stage moves when empty or when downstream takes its request
	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// digit split of all four octets side by side
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bcd_s2[0] <= octet_to_bcd(in_address[31:24]);
			bcd_s2[1] <= octet_to_bcd(in_address[23:16]);
			bcd_s2[2] <= octet_to_bcd(in_address[15:8]);
			bcd_s2[3] <= octet_to_bcd(in_address[7:0]);
		end
	end

	assign out_valid = valid_s2;
	assign out_bcd   = bcd_s2;

endmodule

@@ hdl/ipv4dd_align.sv @@
// pipeline stage that strips leading zeros and records each octet's digit count
module ipv4dd_align (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  ipv4dd_pkg::bcd_quad_t    in_bcd,
	output logic                     out_valid,
	input  logic                     out_ready,
	output ipv4dd_pkg::digits_quad_t out_digits
);
	import ipv4dd_pkg::*;

	logic         valid_s3;
	digits_quad_t digits_s3;

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// left align the significant digits of every octet
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int i = 0; i < 4; i++) begin
				digits_s3[i] <= bcd_to_digits(in_bcd[i]);
			end
		end
	end

	assign out_valid  = valid_s3;
	assign out_digits = digits_s3;

endmodule

@@ hdl/ipv4dd_serial.sv @@
// output stage that walks the octets and sends one character per request
module ipv4dd_serial (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  ipv4dd_pkg::digits_quad_t in_digits,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [5:0]               out_char,
	output logic                     out_last
);
	import ipv4dd_pkg::*;

	logic         busy_q;
	logic [1:0]   oct_q;
	logic [1:0]   pos_q;
	digits_quad_t item_q;

	digits_t      cur;
	logic [3:0]   cur_digit;
	logic         at_dot;
	logic         end_char;

	// current octet and the character at the walk position
	always_comb begin
		cur    = item_q[oct_q];
		at_dot = (pos_q == cur.last_idx + 2'd1);
		unique case (pos_q)
			2'd0:    cur_digit = cur.d0;
			2'd1:    cur_digit = cur.d1;
			default: cur_digit = cur.d2;
		endcase
		end_char = (oct_q == 2'd3) && (pos_q == cur.last_idx);
	end

	assign out_valid = busy_q;
	assign out_char  = at_dot ? ASCII_DOT : (ASCII_ZERO + {2'b00, cur_digit});
	assign out_last  = end_char;

	// a new address loads when idle or as the final character leaves
	assign in_ready = !busy_q || (out_ready && end_char);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			oct_q  <= 2'd0;
			pos_q  <= 2'd0;
		end else if (in_ready) begin
			busy_q <= in_valid;
			oct_q  <= 2'd0;
			pos_q  <= 2'd0;
		end else if (out_ready) begin
			if (at_dot) begin
				oct_q <= oct_q + 2'd1;
				pos_q <= 2'd0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= in_digits;
		end
	end

endmodule

@@ hdl/ipv4_dotted_decimal_format.sv @@
// top level of the ipv4 address to dotted-decimal text formatter
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+--------------------------
//   address  | address_valid, address_ready | address[31:0]
//   text     | text_valid, text_ready       | text_char[5:0], last
//
// one address gives 7 to 15 characters, one per cycle at the text port while
// text_ready is high; the character walker sets that pace.
// an address passes the input register, the digit split and the zero strip
// registers, then loads into the walker, before its first character is offered.
// reset clears only valid and walker state; stalls hold every stage in place.
module ipv4_dotted_decimal_format (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        address_valid,
	output logic        address_ready,
	input  logic [31:0] address,
	output logic        text_valid,
	input  logic        text_ready,
	output logic [5:0]  text_char,
	output logic        last
);
	import ipv4dd_pkg::*;

	logic         valid_s1;
	logic [31:0]  address_s1;
	logic         split_ready;
	logic         split_valid;
	bcd_quad_t    split_bcd;
	logic         align_ready;
	logic         align_valid;
	digits_quad_t align_digits;
	logic         serial_ready;

	// input register stage
	assign address_ready = !valid_s1 || split_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (address_ready) begin
			valid_s1 <= address_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (address_ready && address_valid) begin
			address_s1 <= address;
		end
	end

	// digit split
	ipv4dd_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s1),
		.in_ready   (split_ready),
		.in_address (address_s1),
		.out_valid  (split_valid),
		.out_ready  (align_ready),
		.out_bcd    (split_bcd)
	);

	// leading zero removal
	ipv4dd_align u_align (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (split_valid),
		.in_ready   (align_ready),
		.in_bcd     (split_bcd),
		.out_valid  (align_valid),
		.out_ready  (serial_ready),
		.out_digits (align_digits)
	);

	// character walker
	ipv4dd_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (align_valid),
		.in_ready  (serial_ready),
		.in_digits (align_digits),
		.out_valid (text_valid),
		.out_ready (text_ready),
		.out_char  (text_char),
		.out_last  (last)
	);

endmodule
